>>> hw/rtl/hidis_pkg.sv
// Package for the HID input-report idle scheduler.
// Holds the item types, event and register codes, the state machine states and the slot sizes.
// No dependencies.
package hidis_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = 3;
    localparam int IDX_W     = SLOT_W + 1;
    localparam int RATE_W    = 8;
    localparam int ID_W      = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [IDX_W-1:0] SLOTS_MAX = IDX_W'(NUM_SLOTS);

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_CHANGED  = 2'd1,
        FUNC_XFER_DONE = 2'd2,
        FUNC_SET_IDLE = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_REPORTS = 2'd0,
        CFG_INPUT_MASK  = 2'd1,
        CFG_REPORT_IDS  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_func             func;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   rep_id;
        logic [RATE_W-1:0] idle_rate;
    } t_in_item;

    typedef struct packed {
        logic              send;
        logic [SLOT_W-1:0] send_slot;
        logic              busy_now;
    } t_out_item;

    // Per-slot scheduler state.
    typedef struct packed {
        logic              changed;
        logic [RATE_W-1:0] setting;
        logic [RATE_W-1:0] counter;
    } t_slot_ent;

    // Control for the slot-file write and mark ports.
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_idx;
        logic              mark_en;
        logic [SLOT_W-1:0] mark_idx;
    } t_slot_ctl;

endpackage

>>> hw/rtl/hidis_slot_file.sv
// Per-slot state store: changed flag, idle setting and idle counter for each slot.
// One read port, one write port for the scan and one port that marks a slot changed.
// Depends on hidis_pkg.
module hidis_slot_file (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hidis_pkg::t_slot_ctl          i_ctl,
    input  hidis_pkg::t_slot_ent          i_wr_ent,
    input  logic [hidis_pkg::SLOT_W-1:0]  i_rd_idx,
    output hidis_pkg::t_slot_ent          o_rd_ent
);

    hidis_pkg::t_slot_ent r_ent [hidis_pkg::NUM_SLOTS];

    assign o_rd_ent = r_ent[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hidis_pkg::NUM_SLOTS; i++) begin
                r_ent[i].changed <= 1'b1;
                r_ent[i].setting <= '0;
                r_ent[i].counter <= '0;
            end
        end else begin
            if (i_ctl.wr_en) begin
                r_ent[i_ctl.wr_idx] <= i_wr_ent;
            end
            if (i_ctl.mark_en) begin
                r_ent[i_ctl.mark_idx].changed <= 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/hidis_slot_alu.sv
// Shared slot update unit, used once per scanned slot.
// Applies the tick increment or the idle-rate write, then tests the slot for a pick.
// Depends on hidis_pkg.
module hidis_slot_alu (
    input  hidis_pkg::t_slot_ent             i_ent,
    input  hidis_pkg::t_func                 i_func,
    input  logic [hidis_pkg::RATE_W-1:0]     i_rate,
    input  logic                             i_is_input,
    input  logic                             i_id_match,
    input  logic                             i_pick_en,
    output hidis_pkg::t_slot_ent             o_ent,
    output logic                             o_hit
);

    hidis_pkg::t_slot_ent upd;
    logic                 due;

    always_comb begin
        upd = i_ent;
        if (i_is_input) begin
            if (i_func == hidis_pkg::FUNC_TICK && upd.setting != '0 && upd.counter != '1) begin
                upd.counter = upd.counter + 1'b1;
            end
            if (i_func == hidis_pkg::FUNC_SET_IDLE && i_id_match) begin
                upd.setting = i_rate;
            end
        end
        due   = upd.changed || (upd.setting != '0 && upd.counter >= upd.setting);
        o_hit = i_pick_en && i_is_input && due;
        o_ent = upd;
        if (o_hit) begin
            o_ent.counter = '0;
            o_ent.changed = 1'b0;
        end
    end

endmodule

>>> hw/rtl/hid_in_report_idle_scheduler_core.sv
// HID input-report idle scheduler, top level: sequencer, configuration and output register.
// The slot scan runs one slot per cycle through a single update unit; a new item is
// taken only after the previous result has been loaded into the output register,
// which waits while a result there is stalled.
// Reset (synchronous, active low) marks every slot changed, clears rates, counters,
// busy flag and configuration registers, and empties the output register.
module hid_in_report_idle_scheduler_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  hidis_pkg::t_in_item               i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output hidis_pkg::t_out_item              o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hidis_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                       i_cfg_data
);

    hidis_pkg::t_state                r_state, n_state;
    hidis_pkg::t_in_item              r_item;
    logic [hidis_pkg::IDX_W-1:0]      r_idx;
    logic                             r_found;
    logic [hidis_pkg::SLOT_W-1:0]     r_pick;
    logic                             r_do_pick;
    logic                             r_busy;
    logic                             r_out_valid;
    hidis_pkg::t_out_item             r_out_data;
    logic [3:0]                       r_cfg_num;
    logic [7:0]                       r_cfg_mask;
    logic [63:0]                      r_cfg_ids;

    logic                             in_acc;
    logic                             scan_act;
    logic                             out_load;
    logic [hidis_pkg::IDX_W-1:0]      in_use;
    logic [hidis_pkg::SLOT_W-1:0]     slot_idx;
    logic [hidis_pkg::ID_W-1:0]       slot_id;
    hidis_pkg::t_slot_ctl             slot_ctl;
    hidis_pkg::t_slot_ent             rd_ent;
    hidis_pkg::t_slot_ent             wr_ent;
    logic                             hit;
    logic                             pick_req;

    assign in_use   = (r_cfg_num > hidis_pkg::SLOTS_MAX) ? hidis_pkg::SLOTS_MAX : r_cfg_num;
    assign slot_idx = r_idx[hidis_pkg::SLOT_W-1:0];
    assign slot_id  = r_cfg_ids[{slot_idx, 3'b000} +: hidis_pkg::ID_W];

    assign o_in_stall  = (r_state != hidis_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A pick follows a transfer-done event always, and a tick or report change if free.
    always_comb begin
        pick_req = 1'b0;
        unique case (i_in_data.func)
            hidis_pkg::FUNC_XFER_DONE: pick_req = 1'b1;
            hidis_pkg::FUNC_TICK,
            hidis_pkg::FUNC_CHANGED:   pick_req = !r_busy;
            default:                   pick_req = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hidis_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = hidis_pkg::ST_SCAN;
                end
            end
            hidis_pkg::ST_SCAN: begin
                if (r_idx >= in_use) begin
                    n_state = hidis_pkg::ST_DONE;
                end
            end
            hidis_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = hidis_pkg::ST_IDLE;
                end
            end
            default: n_state = hidis_pkg::ST_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb begin
        in_acc   = 1'b0;
        scan_act = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            hidis_pkg::ST_IDLE: in_acc   = i_in_valid;
            hidis_pkg::ST_SCAN: scan_act = (r_idx < in_use);
            hidis_pkg::ST_DONE: out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    always_comb begin
        slot_ctl.wr_en    = scan_act;
        slot_ctl.wr_idx   = slot_idx;
        slot_ctl.mark_en  = in_acc && (i_in_data.func == hidis_pkg::FUNC_CHANGED)
                            && ({1'b0, i_in_data.slot} < hidis_pkg::SLOTS_MAX);
        slot_ctl.mark_idx = i_in_data.slot;
    end

    hidis_slot_file u_slot_file (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (slot_ctl),
        .i_wr_ent (wr_ent),
        .i_rd_idx (slot_idx),
        .o_rd_ent (rd_ent)
    );

    hidis_slot_alu u_slot_alu (
        .i_ent      (rd_ent),
        .i_func     (r_item.func),
        .i_rate     (r_item.idle_rate),
        .i_is_input (r_cfg_mask[slot_idx]),
        .i_id_match ((r_item.rep_id == '0) || (r_item.rep_id == slot_id)),
        .i_pick_en  (r_do_pick && !r_found),
        .o_ent      (wr_ent),
        .o_hit      (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hidis_pkg::ST_IDLE;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_pick      <= '0;
            r_do_pick   <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg_num   <= '0;
            r_cfg_mask  <= '0;
            r_cfg_ids   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    hidis_pkg::CFG_NUM_REPORTS: r_cfg_num  <= i_cfg_data[3:0];
                    hidis_pkg::CFG_INPUT_MASK:  r_cfg_mask <= i_cfg_data[7:0];
                    hidis_pkg::CFG_REPORT_IDS:  r_cfg_ids  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_idx     <= '0;
                r_found   <= 1'b0;
                r_pick    <= '0;
                r_do_pick <= pick_req;
            end
            if (scan_act) begin
                r_idx <= r_idx + 1'b1;
                if (hit) begin
                    r_found <= 1'b1;
                    r_pick  <= slot_idx;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (r_do_pick) begin
                    r_busy <= r_found;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        if (out_load) begin
            r_out_data.send      <= r_found;
            r_out_data.send_slot <= r_found ? r_pick : '0;
            r_out_data.busy_now  <= r_do_pick ? r_found : r_busy;
        end
    end

endmodule

>>> hw/rtl/hidis_checker.sv
// Port-level checker for the HID input-report idle scheduler, bound to the top level.
// Depends on hidis_pkg and hid_in_report_idle_scheduler_core.
module hidis_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  hidis_pkg::t_in_item               i_in_data,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  hidis_pkg::t_out_item              o_out_data
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // A result that waits on the consumer holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // No slot number is reported without a transfer start.
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.send |-> o_out_data.send_slot == '0)
        else $error("slot reported without send");

    // Starting a transfer leaves the endpoint busy.
    a_send_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.send |-> o_out_data.busy_now)
        else $error("send without busy");

    // The block is occupied in the cycle after it takes an item.
    a_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("new item taken during a scan");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule

bind hid_in_report_idle_scheduler_core hidis_checker u_hidis_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
